### hdl/oaht_pkg.sv
`default_nettype none

package oaht_pkg;

    // Default sizes of the table and of the probe sequence.
    localparam int TABLE_SIZE_DEF  = 16;
    localparam int PROBE_COUNT_DEF = 12;

    // Field widths of a request word and of a response word.
    localparam int YEAR_W   = 12;
    localparam int SPEED_W  = 16;
    localparam int MARK_W   = 32;
    localparam int KEY_W    = YEAR_W + SPEED_W + MARK_W;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Probe step registers: six 8-bit steps in each register.
    localparam int STEP_W    = 8;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_STEPS = 12;

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // Response status codes.
    localparam t_status ST_INSERTED  = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_FOUND     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_HIGH = 1'd1;

    // One slot as read back from the table store.
    typedef struct packed {
        logic valid;
        t_key key;
    } t_slot_rd;

endpackage

`default_nettype wire

### hdl/oaht_in_if.sv
`default_nettype none

// Request channel: one word is an insert or a find of one key.
interface oaht_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [oaht_pkg::YEAR_W-1:0]  key_year;
    logic [oaht_pkg::SPEED_W-1:0] key_speed;
    logic [oaht_pkg::MARK_W-1:0]  mark_code;

    modport source (output valid, opcode, key_year, key_speed, mark_code, input ready);
    modport sink (input valid, opcode, key_year, key_speed, mark_code, output ready);
endinterface

`default_nettype wire

### hdl/oaht_out_if.sv
`default_nettype none

// Response channel: one word per request.
interface oaht_out_if;
    logic                         valid;
    logic                         ready;
    logic [oaht_pkg::STATUS_W-1:0] status;
    logic [oaht_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, status, slot, input ready);
    modport sink (input valid, status, slot, output ready);
endinterface

`default_nettype wire

### hdl/oaht_store.sv
`default_nettype none

// Table store: key memory with one registered read port and one write port,
// plus a valid flag per slot that reset clears.
module oaht_store #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
    localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [IDX_W-1:0]     i_rd_addr,
    input  wire logic                 i_wr_en,
    input  wire logic [IDX_W-1:0]     i_wr_addr,
    input  wire oaht_pkg::t_key       i_wr_key,
    output oaht_pkg::t_slot_rd        o_rd
);

    oaht_pkg::t_key r_key_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_valid;
    oaht_pkg::t_key r_rd_key;
    logic r_rd_valid;

    // Key memory: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_key <= r_key_mem[i_rd_addr];
    end

    // Valid flags, cleared by reset, read alongside the key memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.key   = r_rd_key;

endmodule

`default_nettype wire

### hdl/open_addressing_hash_table.sv
// Channel    Direction  Word contents                          Accepted when
// i_req      in         opcode, key_year, key_speed, mark_code  valid && ready
// o_rsp      out        status, slot                           valid && ready
// i_cfg_*    in         register index, 48-bit write data      i_cfg_we
//
// After acceptance an item first reduces the year to the home slot, then
// probes one slot at a time, bounded by the single read port of the key
// memory, with the result loaded on the last probe if the output is free.
// An item probes at most PROBE_COUNT slots, counted from the home slot on.
// Reset empties the table at once and clears the probe steps.
// A stalled response holds; the next item may be accepted while it waits,
// and its own result then waits one extra state until the output is free.
`default_nettype none

module open_addressing_hash_table #(
    parameter int TABLE_SIZE  = oaht_pkg::TABLE_SIZE_DEF,
    parameter int PROBE_COUNT = oaht_pkg::PROBE_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    oaht_in_if.sink                                i_req,
    oaht_out_if.source                             o_rsp,
    input  wire logic                              i_cfg_we,
    input  wire logic [oaht_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [oaht_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int PROBE_W = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
    localparam int YEAR_W  = oaht_pkg::YEAR_W;

    // Exact reciprocal for year / TABLE_SIZE over all years.
    localparam int RECIP_SH = YEAR_W + IDX_W;
    localparam int RECIP_M  = ((1 << RECIP_SH) + TABLE_SIZE - 1) / TABLE_SIZE;
    localparam int RECIP_W  = YEAR_W + 2;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_M);
    localparam logic [IDX_W:0]     TSIZE = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(PROBE_COUNT - 1);

    // State codes.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_HOME   = 2'd1;
    localparam logic [1:0] S_PROBE  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    // Reduce an 8-bit probe step modulo the table size by compare and subtract.
    function automatic logic [IDX_W-1:0] step_mod(input logic [oaht_pkg::STEP_W-1:0] s);
        logic [oaht_pkg::STEP_W:0] v;
        v = {1'b0, s};
        for (int k = oaht_pkg::STEP_W - 1; k >= 0; k--) begin
            if ((TABLE_SIZE << k) < (1 << oaht_pkg::STEP_W)) begin
                if (v >= (oaht_pkg::STEP_W + 1)'(TABLE_SIZE << k)) begin
                    v = v - (oaht_pkg::STEP_W + 1)'(TABLE_SIZE << k);
                end
            end
        end
        return v[IDX_W-1:0];
    endfunction

    logic [1:0]                      r_state;
    logic [oaht_pkg::CFG_W-1:0]      r_steps_low;
    logic [oaht_pkg::CFG_W-1:0]      r_steps_high;
    logic                            r_op;
    oaht_pkg::t_key                  r_key;
    logic [YEAR_W-1:0]               r_quot;
    logic [IDX_W-1:0]                r_idx;
    logic [PROBE_W-1:0]              r_probe;
    logic                            r_out_valid;
    oaht_pkg::t_status               r_status;
    logic [oaht_pkg::SLOT_W-1:0]     r_slot;
    oaht_pkg::t_status               r_pend_status;
    logic [oaht_pkg::SLOT_W-1:0]     r_pend_slot;

    logic [YEAR_W+RECIP_W-1:0]       quot_prod;
    logic [YEAR_W+IDX_W:0]           back_prod;
    logic [YEAR_W-1:0]               year_rem;
    logic [IDX_W-1:0]                home_idx;
    logic [2*oaht_pkg::CFG_W-1:0]    steps_all;
    logic [3:0]                      probe_sel;
    logic [oaht_pkg::STEP_W-1:0]     step_raw;
    logic [IDX_W:0]                  idx_sum;
    logic [IDX_W-1:0]                next_idx;
    logic [IDX_W-1:0]                rd_addr;
    oaht_pkg::t_slot_rd              slot_rd;
    logic                            stop;
    logic                            decide;
    logic                            out_free;
    logic                            out_load;
    oaht_pkg::t_status               res_status;
    logic [oaht_pkg::SLOT_W-1:0]     res_slot;
    logic                            wr_en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_low  <= '0;
            r_steps_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                oaht_pkg::CFG_STEPS_LOW:  r_steps_low  <= i_cfg_data;
                oaht_pkg::CFG_STEPS_HIGH: r_steps_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Home slot: quotient by reciprocal at acceptance, remainder in the S_HOME state that follows.
    assign quot_prod = (YEAR_W + RECIP_W)'(i_req.key_year) * (YEAR_W + RECIP_W)'(RECIP);
    assign back_prod = (YEAR_W + IDX_W + 1)'(r_quot) * (YEAR_W + IDX_W + 1)'(TSIZE);
    assign year_rem  = r_key[oaht_pkg::KEY_W-1 -: YEAR_W] - back_prod[YEAR_W-1:0];
    assign home_idx  = year_rem[IDX_W-1:0];

    // Next probe slot: add the reduced step and wrap once.
    assign steps_all = {r_steps_high, r_steps_low};
    assign probe_sel = 4'(r_probe);
    assign step_raw  = steps_all[oaht_pkg::STEP_W*probe_sel +: oaht_pkg::STEP_W];
    assign idx_sum   = {1'b0, r_idx} + {1'b0, step_mod(step_raw)};
    assign next_idx  = (idx_sum >= TSIZE) ? IDX_W'(idx_sum - TSIZE) : idx_sum[IDX_W-1:0];

    // Probe decision on the slot read in the previous cycle.
    assign stop     = !slot_rd.valid || (slot_rd.key == r_key);
    assign decide   = (r_state == S_PROBE) && (stop || (r_probe == LAST_PROBE));
    assign out_free = !r_out_valid || o_rsp.ready;
    assign out_load = (decide || (r_state == S_RESULT)) && out_free;
    assign wr_en    = decide && stop && (r_op == oaht_pkg::OP_INSERT);

    always_comb begin
        res_status = oaht_pkg::ST_NOT_FOUND;
        res_slot   = '0;
        if (r_op == oaht_pkg::OP_INSERT) begin
            if (stop) begin
                res_status = oaht_pkg::ST_INSERTED;
                res_slot   = oaht_pkg::SLOT_W'(r_idx);
            end else begin
                res_status = oaht_pkg::ST_FULL;
            end
        end else if (stop && slot_rd.valid) begin
            res_status = oaht_pkg::ST_FOUND;
            res_slot   = oaht_pkg::SLOT_W'(r_idx);
        end
    end

    // Read address of the table store.
    always_comb begin
        unique case (r_state)
            S_HOME:  rd_addr = home_idx;
            S_PROBE: rd_addr = next_idx;
            default: rd_addr = r_idx;
        endcase
    end

    oaht_store #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_key  (r_key),
        .o_rd      (slot_rd)
    );

    // Sequencer for one request at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_HOME;
                    end
                end
                S_HOME: begin
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    if (decide) begin
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Request, probe and result payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op   <= i_req.opcode;
            r_key  <= {i_req.key_year, i_req.key_speed, i_req.mark_code};
            r_quot <= YEAR_W'(quot_prod >> RECIP_SH);
        end
        if (r_state == S_HOME) begin
            r_idx   <= home_idx;
            r_probe <= '0;
        end else if (r_state == S_PROBE && !decide) begin
            r_idx   <= next_idx;
            r_probe <= r_probe + 1'b1;
        end
        if (decide) begin
            r_pend_status <= res_status;
            r_pend_slot   <= res_slot;
            if (out_free) begin
                r_status <= res_status;
                r_slot   <= res_slot;
            end
        end else if (r_state == S_RESULT && out_free) begin
            r_status <= r_pend_status;
            r_slot   <= r_pend_slot;
        end
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.slot   = r_slot;

    // The table is written only on the deciding probe of an insert.
    a_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_PROBE && r_op == oaht_pkg::OP_INSERT))
        else $error("table write outside an insert probe");

    // The probe index stays inside the table and the count inside the sequence.
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_idx < TSIZE && r_probe <= LAST_PROBE))
        else $error("probe slot or count out of range");

    // Full and not-found responses carry slot zero.
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == oaht_pkg::ST_FULL ||
                         o_rsp.status == oaht_pkg::ST_NOT_FOUND)) |-> (o_rsp.slot == '0))
        else $error("miss response with nonzero slot");

    // A home slot cycle always follows an accepted request.
    a_home_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_HOME))
        else $error("accepted request did not start a search");

endmodule

`default_nettype wire
